// File: hdl/nfe_pkg.sv
// Package for the NFLOG-to-Ethernet reframer: record phases, status codes,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package nfe_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned ByteCntW = 16;
  localparam int unsigned HdrCntW  = 4;

  localparam logic [ByteCntW-1:0] MaxFrameBytes = 16'hFFFF;
  localparam logic [HdrCntW-1:0]  HdrLastIdx    = 4'd13;

  localparam logic [AddrW-1:0] FirstAddrRst    = 48'h1111_1111_1111;
  localparam logic [AddrW-1:0] SecondAddrRst   = 48'h2222_2222_1111;
  localparam logic [15:0]      EthertypeRst    = 16'h0800;
  localparam logic [7:0]       AcceptFamilyRst = 8'h02;
  localparam logic [15:0]      PayloadTypeRst  = 16'h0009;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstAddr    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondAddr   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEthertype    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAcceptFamily = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPayloadType  = 3'd4;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DROP = 2'd1,
    ST_MALF = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    PH_HDR     = 5'b00001,
    PH_TLV     = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAY     = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_e;

endpackage

// File: hdl/nflog_to_ethernet_reframer.sv
// NFLOG-to-Ethernet reframer top level: frame parser, header generator and
// two-entry output stage. Depends on nfe_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: one NFLOG frame byte per transaction (in_byte_i) with
//   in_last_i on the final byte. Output channel: one Ethernet byte per
//   transaction with out_last_o on the final one; out_status_o is 0 for data,
//   1 when the frame was dropped for a wrong family byte, 2 when malformed.
//   Dropped and malformed frames give a single status transaction (byte 0).
//   Configuration: cfg_wr_en_i writes cfg_data_i into register cfg_index_i;
//   write only while no frame is in flight.
// Timing
//   Every input byte is parsed in the cycle it is accepted; its result is
//   registered in the output or skid register. One byte is accepted per cycle
//   while in_stall_o is low. When the payload record header completes, the
//   input stalls as the 14 header bytes go out, one per cycle while the skid is empty.
// Stall behavior
//   A skid register behind the output register takes one result while the
//   receiver stalls; the input stall comes from registers only.
// Reset
//   All frame state clears, the output channel empties, and the
//   configuration registers return to their default values.
module nflog_to_ethernet_reframer
  import nfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic [1:0]          out_status_o
);

  // Configuration registers
  logic [AddrW-1:0] first_addr_q, second_addr_q;
  logic [15:0]      ethertype_q, payload_type_q;
  logic [7:0]       accept_family_q;

  // Frame state
  phase_e              phase_q, phase_d;
  logic [ByteCntW-1:0] byte_count_q, byte_count_d;
  logic [15:0]         rec_len_q, rec_len_d;
  logic [7:0]          rec_type_lo_q, rec_type_lo_d;
  logic                family_bad_q, family_bad_d;

  // Header generator
  logic               hdr_busy_q;
  logic [HdrCntW-1:0] hdr_cnt_q;
  logic               hdr_last_q;
  logic               hdr_start;
  logic [7:0]         hdr_byte;

  // Output stage: output register plus skid register
  logic       out_valid_q, skid_valid_q;
  logic [7:0] out_byte_q, skid_byte_q;
  logic       out_last_q, skid_last_q;
  logic [1:0] out_status_q, skid_status_q;

  // Item produced this cycle
  logic       in_fire;
  logic       p_in_valid, p_valid, p_last, p_in_last;
  logic [7:0] p_in_byte, p_byte;
  logic [1:0] p_in_status, p_status;
  logic       hdr_emit;

  logic                over;
  logic [16:0]         len_round;
  logic [15:0]         rec_type_full;

  assign in_stall_o = hdr_busy_q | skid_valid_q;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_addr_q    <= FirstAddrRst;
      second_addr_q   <= SecondAddrRst;
      ethertype_q     <= EthertypeRst;
      accept_family_q <= AcceptFamilyRst;
      payload_type_q  <= PayloadTypeRst;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_index_i)
        CfgFirstAddr:    first_addr_q    <= cfg_data_i[AddrW-1:0];
        CfgSecondAddr:   second_addr_q   <= cfg_data_i[AddrW-1:0];
        CfgEthertype:    ethertype_q     <= cfg_data_i[15:0];
        CfgAcceptFamily: accept_family_q <= cfg_data_i[7:0];
        CfgPayloadType:  payload_type_q  <= cfg_data_i[15:0];
        default: ;  // unmapped index: ignore
      endcase
    end
  end

  // Parse one accepted byte
  assign over          = (byte_count_q == MaxFrameBytes);
  assign rec_type_full = {in_byte_i, rec_type_lo_q};
  // Round the record length up to a multiple of four, minus the 4-byte record header
  assign len_round     = (({1'b0, rec_len_q} + 17'd3) & ~17'd3) - 17'd4;

  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    rec_len_d     = rec_len_q;
    rec_type_lo_d = rec_type_lo_q;
    family_bad_d  = family_bad_q;
    hdr_start     = 1'b0;
    p_in_valid    = 1'b0;
    p_in_byte     = in_byte_i;
    p_in_last     = in_last_i;
    p_in_status   = ST_DATA;

    if (in_fire) begin
      if (!over) begin
        byte_count_d = byte_count_q + 16'd1;
      end

      unique case (phase_q)
        PH_HDR: begin
          if (byte_count_q == '0 && in_byte_i != accept_family_q) begin
            family_bad_d = 1'b1;
            phase_d      = PH_DISCARD;
          end else if (over) begin
            phase_d = PH_DISCARD;
          end else if (byte_count_q == 16'd3) begin
            phase_d = PH_TLV;
          end
        end
        PH_TLV: begin
          if (over) begin
            phase_d = PH_DISCARD;
          end else begin
            case (byte_count_q[1:0])
              2'd0: rec_len_d = {8'd0, in_byte_i};
              2'd1: rec_len_d = {in_byte_i, rec_len_q[7:0]};
              2'd2: rec_type_lo_d = in_byte_i;
              default: begin
                rec_type_lo_d = 8'd0;
                if (rec_type_full == payload_type_q) begin
                  hdr_start = 1'b1;
                  phase_d   = PH_PAY;
                end else if (rec_len_q < 16'd4) begin
                  phase_d = PH_DISCARD;
                end else begin
                  rec_len_d = len_round[15:0];
                  phase_d   = (len_round[15:0] != '0) ? PH_SKIP : PH_TLV;
                end
              end
            endcase
          end
        end
        PH_SKIP: begin
          if (over) begin
            phase_d = PH_DISCARD;
          end else begin
            rec_len_d = rec_len_q - 16'd1;
            if (rec_len_q == 16'd1) begin
              phase_d = PH_TLV;
            end
          end
        end
        PH_PAY: begin
          p_in_valid = 1'b1;  // forward the payload byte
        end
        PH_DISCARD: ;  // swallow
        default: ;
      endcase

      if (in_last_i) begin
        // Frames that never reached the payload end in one status transaction
        if (phase_d != PH_PAY) begin
          p_in_valid  = 1'b1;
          p_in_byte   = 8'd0;
          p_in_last   = 1'b1;
          p_in_status = family_bad_d ? ST_DROP : ST_MALF;
        end
        phase_d       = PH_HDR;
        byte_count_d  = '0;
        rec_len_d     = '0;
        rec_type_lo_d = '0;
        family_bad_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HDR;
      byte_count_q  <= '0;
      rec_len_q     <= '0;
      rec_type_lo_q <= '0;
      family_bad_q  <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      rec_len_q     <= rec_len_d;
      rec_type_lo_q <= rec_type_lo_d;
      family_bad_q  <= family_bad_d;
    end
  end

  // Header generator: 14 bytes, one per cycle, while the skid register is free
  assign hdr_emit = hdr_busy_q & ~skid_valid_q;

  always_comb begin
    case (hdr_cnt_q)
      4'd0:    hdr_byte = first_addr_q[47:40];
      4'd1:    hdr_byte = first_addr_q[39:32];
      4'd2:    hdr_byte = first_addr_q[31:24];
      4'd3:    hdr_byte = first_addr_q[23:16];
      4'd4:    hdr_byte = first_addr_q[15:8];
      4'd5:    hdr_byte = first_addr_q[7:0];
      4'd6:    hdr_byte = second_addr_q[47:40];
      4'd7:    hdr_byte = second_addr_q[39:32];
      4'd8:    hdr_byte = second_addr_q[31:24];
      4'd9:    hdr_byte = second_addr_q[23:16];
      4'd10:   hdr_byte = second_addr_q[15:8];
      4'd11:   hdr_byte = second_addr_q[7:0];
      4'd12:   hdr_byte = ethertype_q[15:8];
      4'd13:   hdr_byte = ethertype_q[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_busy_q <= 1'b0;
      hdr_cnt_q  <= '0;
      hdr_last_q <= 1'b0;
    end else if (hdr_start) begin
      hdr_busy_q <= 1'b1;
      hdr_cnt_q  <= '0;
      hdr_last_q <= in_last_i;  // empty payload: header carries the frame end
    end else if (hdr_emit) begin
      hdr_cnt_q <= hdr_cnt_q + 4'd1;
      if (hdr_cnt_q == HdrLastIdx) begin
        hdr_busy_q <= 1'b0;
      end
    end
  end

  // Merge the two producers; they never fire in the same cycle
  assign p_valid  = hdr_emit | p_in_valid;
  assign p_byte   = hdr_emit ? hdr_byte : p_in_byte;
  assign p_last   = hdr_emit ? (hdr_last_q & (hdr_cnt_q == HdrLastIdx)) : p_in_last;
  assign p_status = hdr_emit ? ST_DATA : p_in_status;

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q | p_valid;
      skid_valid_q <= skid_valid_q & p_valid;
    end else if (p_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_byte_q    <= skid_byte_q;
        out_last_q    <= skid_last_q;
        out_status_q  <= skid_status_q;
        skid_byte_q   <= p_byte;
        skid_last_q   <= p_last;
        skid_status_q <= p_status;
      end else begin
        out_byte_q   <= p_byte;
        out_last_q   <= p_last;
        out_status_q <= p_status;
      end
    end else if (p_valid) begin
      skid_byte_q   <= p_byte;
      skid_last_q   <= p_last;
      skid_status_q <= p_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

  // Header insertion must hold off the input
  a_hdr_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_busy_q |-> in_stall_o)
    else $error("input not stalled during header insertion");

  // Skid register is only filled behind a held output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full with output register empty");

  // Payload record match starts the header generator
  a_hdr_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_start |=> hdr_busy_q && hdr_cnt_q == '0)
    else $error("header generator did not start");

  // Status transactions close the frame and carry a zero byte
  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_DATA |-> out_last_q && out_byte_q == 8'd0)
    else $error("malformed status transaction");

  // Header counter stays within the 14 header bytes
  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_busy_q |-> hdr_cnt_q <= HdrLastIdx)
    else $error("header counter out of range");

endmodule

// File: test/nfe_reframer_checker.sv
// Scoreboard for the NFLOG-to-Ethernet reframer: mirrors the register file, predicts the
// Ethernet byte stream per accepted input byte and compares it with the output channel.
// Depends on nfe_pkg.
`timescale 1ns / 1ps

module nfe_reframer_checker
  import nfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [7:0]          out_byte_i,
  input  logic                out_last_i,
  input  logic [1:0]          out_status_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_e    status;
  } eth_beat_t;

  eth_beat_t eth_beats_due[$];

  logic [AddrW-1:0] first_addr_q;
  logic [AddrW-1:0] second_addr_q;
  logic [15:0]      ethertype_q;
  logic [7:0]       family_q;
  logic [15:0]      ptype_q;

  phase_e        phase_q;
  logic [15:0]   pos_count;
  logic [15:0]   rec_len;
  logic [15:0]   rec_type;
  logic          bad_family;
  int unsigned   errors;
  int unsigned   checked;

  function automatic void due_beat(input logic [7:0] d, input logic l, input status_e s);
    eth_beat_t beat;
    beat.data   = d;
    beat.last   = l;
    beat.status = s;
    eth_beats_due.push_back(beat);
  endfunction

  function automatic void clear_frame();
    phase_q    = PH_HDR;
    pos_count  = '0;
    rec_len    = '0;
    rec_type   = '0;
    bad_family = 1'b0;
  endfunction

  // Advance the parser by one frame byte and queue the Ethernet bytes it yields.
  function automatic void parse_nflog_byte(input logic [7:0] b, input logic l);
    logic [15:0] pos;
    logic        over;
    logic [31:0] padded;
    int          n_before;
    eth_beat_t   tail;
    pos      = pos_count;
    over     = (pos == MaxFrameBytes);
    n_before = eth_beats_due.size();
    if (!over) pos_count = pos + 16'd1;

    case (phase_q)
      PH_HDR: begin
        if (pos == 16'd0 && b != family_q) begin
          bad_family = 1'b1;
          phase_q    = PH_DISCARD;
        end else if (over) begin
          phase_q = PH_DISCARD;
        end else if (pos == 16'd3) begin
          phase_q = PH_TLV;
        end
      end
      PH_TLV: begin
        if (over) begin
          phase_q = PH_DISCARD;
        end else begin
          case (pos[1:0])
            2'd0: rec_len = {8'h00, b};
            2'd1: rec_len = {b, rec_len[7:0]};
            2'd2: rec_type = {8'h00, b};
            default: begin
              rec_type = {b, rec_type[7:0]};
              if (rec_type == ptype_q) begin
                for (int k = 0; k < 6; k++) due_beat(first_addr_q[8*(5-k) +: 8], 1'b0, ST_DATA);
                for (int k = 0; k < 6; k++) due_beat(second_addr_q[8*(5-k) +: 8], 1'b0, ST_DATA);
                due_beat(ethertype_q[15:8], 1'b0, ST_DATA);
                due_beat(ethertype_q[7:0], 1'b0, ST_DATA);
                phase_q = PH_PAY;
              end else if (rec_len < 16'd4) begin
                phase_q = PH_DISCARD;
              end else begin
                // round up to the 4-byte boundary, minus the record header
                padded  = (({16'h0000, rec_len} + 32'd3) & 32'hFFFF_FFFC) - 32'd4;
                rec_len = padded[15:0];
                phase_q = (rec_len != 16'd0) ? PH_SKIP : PH_TLV;
              end
            end
          endcase
        end
      end
      PH_SKIP: begin
        if (over) begin
          phase_q = PH_DISCARD;
        end else begin
          rec_len = rec_len - 16'd1;
          if (rec_len == 16'd0) phase_q = PH_TLV;
        end
      end
      PH_PAY: due_beat(b, 1'b0, ST_DATA);
      default: ;
    endcase

    if (l) begin
      if (phase_q == PH_PAY && eth_beats_due.size() > n_before) begin
        tail      = eth_beats_due.pop_back();
        tail.last = 1'b1;
        eth_beats_due.push_back(tail);
      end else begin
        due_beat(8'h00, 1'b1, bad_family ? ST_DROP : ST_MALF);
      end
      clear_frame();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    eth_beat_t exp_beat;
    if (!rst_ni) begin
      eth_beats_due.delete();
      first_addr_q  = FirstAddrRst;
      second_addr_q = SecondAddrRst;
      ethertype_q   = EthertypeRst;
      family_q      = AcceptFamilyRst;
      ptype_q       = PayloadTypeRst;
      clear_frame();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (eth_beats_due.size() == 0) begin
          $display("%0t: unexpected output transaction byte %02h last %0b status %0d",
                   $time, out_byte_i, out_last_i, out_status_i);
          errors++;
        end else begin
          exp_beat = eth_beats_due.pop_front();
          checked++;
          if (out_byte_i !== exp_beat.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_beat.data, out_byte_i);
            errors++;
          end
          if (out_last_i !== exp_beat.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, exp_beat.last, out_last_i);
            errors++;
          end
          if (out_status_i !== exp_beat.status) begin
            $display("%0t: out_status expected %0d actual %0d", $time, exp_beat.status,
                     out_status_i);
            errors++;
          end
        end
      end

      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          CfgFirstAddr:    first_addr_q  = cfg_data_i[AddrW-1:0];
          CfgSecondAddr:   second_addr_q = cfg_data_i[AddrW-1:0];
          CfgEthertype:    ethertype_q   = cfg_data_i[15:0];
          CfgAcceptFamily: family_q      = cfg_data_i[7:0];
          CfgPayloadType:  ptype_q       = cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) parse_nflog_byte(in_byte_i, in_last_i);
    end
    fail_count_o <= errors;
    pending_o    <= eth_beats_due.size();
    checked_o    <= checked;
  end

endmodule

// File: test/nflog_to_ethernet_reframer_tb.sv
// Testbench top for the NFLOG-to-Ethernet reframer: clock, reset, register programming,
// frame stimulus and back-pressure. Depends on nfe_pkg, the reframer and nfe_reframer_checker.
`timescale 1ns / 1ps

module nflog_to_ethernet_reframer_tb;
  import nfe_pkg::*;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned DrainCycles = 24;       // header burst plus output stage
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBytes  = 100;
  localparam int unsigned TimeoutNs   = 12_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_wr_en_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          in_byte_i = '0;
  logic                in_last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                out_last_o;
  logic [1:0]          out_status_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Stimulus knobs and bookkeeping
  int unsigned send_idle_pct = 6;
  int unsigned recv_stall_pct = 48;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned sent_bytes = 0;
  int unsigned sent_frames = 0;
  logic [7:0]  cur_family = AcceptFamilyRst;
  logic [15:0] cur_ptype = PayloadTypeRst;
  logic [7:0]  frame_q[$];

  always #(ClkHalf) clk_i = ~clk_i;

  nflog_to_ethernet_reframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_status_o (out_status_o)
  );

  nfe_reframer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .out_last_i   (out_last_o),
    .out_status_i (out_status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver: stall at random, or hold off for a long stretch once the top asks for it.
  // The hold is counted here so the sender keeps offering bytes meanwhile.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall_i    <= 1'b1;
      hold_left      <= HoldCycles;
      long_hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one byte; idle first at random, then hold the payload until it is taken.
  task automatic push_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_frame();
    int unsigned n;
    for (n = 0; n < frame_q.size(); n++) push_byte(frame_q[n], n == frame_q.size() - 1);
    sent_frames++;
  endtask

  // Drop valid and wait for every expected transaction, then let the pipeline settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [47:0] first, input logic [47:0] second,
                              input logic [47:0] eth, input logic [47:0] fam,
                              input logic [47:0] ptype);
    write_reg(CfgFirstAddr, first);
    write_reg(CfgSecondAddr, second);
    write_reg(CfgEthertype, eth);
    write_reg(CfgAcceptFamily, fam);
    write_reg(CfgPayloadType, ptype);
    cfg_wr_en_i <= 1'b0;
    cur_family = fam[7:0];
    cur_ptype  = ptype[15:0];
  endtask

  function automatic void add_nflog_head(input logic [7:0] fam);
    frame_q.push_back(fam);
    repeat (3) frame_q.push_back(8'($urandom));
  endfunction

  // TLV header: length then type, both little-endian
  function automatic void add_tlv_head(input logic [15:0] len, input logic [15:0] typ);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(typ[7:0]);
    frame_q.push_back(typ[15:8]);
  endfunction

  function automatic void add_random_bytes(input int unsigned count);
    repeat (count) frame_q.push_back(8'($urandom));
  endfunction

  // Mostly well-formed frames: header, a few records to skip, then the payload record.
  // The rest is noise, wrong family, short records and frames cut short.
  function automatic void build_random_frame();
    int unsigned roll;
    int unsigned len;
    int unsigned body;
    int unsigned cut;
    logic [15:0] typ;
    frame_q.delete();
    roll = $urandom_range(99);
    if (roll < 6) begin
      add_random_bytes($urandom_range(1, 12));
    end else begin
      if (roll < 12) add_nflog_head(cur_family ^ 8'($urandom_range(1, 255)));
      else add_nflog_head(cur_family);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(9) == 0) len = $urandom_range(0, 3);
        else if ($urandom_range(19) == 0) len = $urandom_range(4, 300);
        else len = $urandom_range(4, 24);
        typ = 16'($urandom);
        if (typ == cur_ptype) typ = ~typ;
        add_tlv_head(16'(len), typ);
        body = (len < 4) ? $urandom_range(0, 4) : ((len + 3) & 32'hFFFF_FFFC) - 4;
        add_random_bytes(body);
      end
      add_tlv_head(16'($urandom), cur_ptype);
      add_random_bytes($urandom_range(0, 24));
      if (roll < 22) begin
        cut = $urandom_range(1, frame_q.size());
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endfunction

  task automatic run_random_frames();
    int unsigned start;
    start = sent_bytes;
    while (sent_bytes - start < PhaseBytes) begin
      build_random_frame();
      send_frame();
      if ($urandom_range(15) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under reset register values
    frame_q = '{8'h55};                           // wrong family, one-byte frame
    send_frame();
    frame_q.delete();                             // empty payload: header only
    add_nflog_head(cur_family);
    add_tlv_head(16'hFFFF, cur_ptype);
    send_frame();
    frame_q.delete();                             // short record ends the walk
    add_nflog_head(cur_family);
    add_tlv_head(16'h0003, 16'h0001);
    send_frame();
    frame_q.delete();                             // padded record, then one payload byte
    frame_q = '{cur_family, 8'h00, 8'h00, 8'h00};
    add_tlv_head(16'h0006, 16'h0000);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    add_tlv_head(16'h0004, cur_ptype);
    frame_q.push_back(8'hFF);
    send_frame();
    frame_q = '{cur_family, 8'hFF};               // ends inside the NFLOG header
    send_frame();
    drain_results();

    // Random registers, sender idles rarely, receiver stalls often
    program_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}));
    run_random_frames();
    drain_results();

    // Mostly all-ones registers, sender idles often, receiver rarely; long receiver hold first
    send_idle_pct = 48;
    recv_stall_pct <= 6;
    program_regs(48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF, 48'hFF, 48'hFFFF);
    long_hold_req <= 1'b1;
    frame_q.delete();
    add_nflog_head(cur_family);
    add_tlv_head(16'h0004, cur_ptype);
    add_random_bytes(40);
    send_frame();
    run_random_frames();
    drain_results();

    // Mostly all-zeros registers, no idling on either side
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    program_regs(48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 48'h0);
    run_random_frames();
    drain_results();

    $display("Sent %0d frames (%0d bytes), checked %0d output transactions,", sent_frames,
             sent_bytes, checked);
    $display("under reset, random and both extreme register settings with back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

endmodule
